// File: rtl/core/pae_pkg.sv
// Shared types, codes and defaults for the positional array engine.
`timescale 1ns / 1ps

package pae_pkg;

  localparam int DEPTH_DEFAULT = 128;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } st_t;

  // What the entry mover does with each read beat.
  typedef enum logic [1:0] {
    MV_INS,
    MV_DEL,
    MV_SCAN,
    MV_READ
  } mv_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MOVE,
    S_PUT,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     mv_load;
    mv_mode_t mv_mode;
    logic     mv_run;
    logic     put_val;
    logic     cnt_clear;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     res_load;
    st_t      res_status;
    logic     res_rd;
    logic     res_found;
  } pae_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic ins_pos_ok;
    logic pos_ok;
    logic mv_busy;
    logic match;
  } pae_stat_t;

endpackage

// File: rtl/core/pae_ctrl.sv
// Controller state machine: sequences one command through the datapath.
`timescale 1ns / 1ps

module pae_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pae_pkg::pae_stat_t  stat,
  output pae_pkg::pae_cmd_t   cmd,
  output logic                busy,
  output logic                done
);

  pae_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pae_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pae_pkg::S_IDLE: begin
        if (start) state_next = pae_pkg::S_DECIDE;
      end
      pae_pkg::S_DECIDE: begin
        case (stat.op)
          pae_pkg::OP_INSERT: begin
            if (stat.full || !stat.ins_pos_ok) state_next = pae_pkg::S_DONE;
            else state_next = pae_pkg::S_MOVE;
          end
          pae_pkg::OP_DELETE: begin
            if (stat.empty || !stat.pos_ok) state_next = pae_pkg::S_DONE;
            else state_next = pae_pkg::S_MOVE;
          end
          pae_pkg::OP_SEARCH: state_next = pae_pkg::S_SCAN;
          pae_pkg::OP_READ: begin
            if (stat.empty || !stat.pos_ok) state_next = pae_pkg::S_DONE;
            else state_next = pae_pkg::S_READ;
          end
          default: state_next = pae_pkg::S_DONE;
        endcase
      end
      pae_pkg::S_MOVE: begin
        if (!stat.mv_busy) begin
          if (stat.op == pae_pkg::OP_INSERT) state_next = pae_pkg::S_PUT;
          else state_next = pae_pkg::S_DONE;
        end
      end
      pae_pkg::S_PUT: state_next = pae_pkg::S_DONE;
      pae_pkg::S_SCAN: begin
        if (stat.match || !stat.mv_busy) state_next = pae_pkg::S_DONE;
      end
      pae_pkg::S_READ: begin
        if (!stat.mv_busy) state_next = pae_pkg::S_DONE;
      end
      pae_pkg::S_DONE: state_next = pae_pkg::S_IDLE;
      default: state_next = pae_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.mv_mode = pae_pkg::MV_SCAN;
    cmd.res_status = pae_pkg::ST_OK;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      pae_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      pae_pkg::S_DECIDE: begin
        case (stat.op)
          pae_pkg::OP_CLEAR: begin
            cmd.cnt_clear = 1'b1;
            cmd.res_load = 1'b1;
          end
          pae_pkg::OP_INSERT: begin
            if (stat.full) begin
              cmd.res_load = 1'b1;
              cmd.res_status = pae_pkg::ST_FULL;
            end else if (!stat.ins_pos_ok) begin
              cmd.res_load = 1'b1;
              cmd.res_status = pae_pkg::ST_BADPOS;
            end else begin
              cmd.mv_load = 1'b1;
              cmd.mv_mode = pae_pkg::MV_INS;
            end
          end
          pae_pkg::OP_DELETE: begin
            if (stat.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_status = pae_pkg::ST_EMPTY;
            end else if (!stat.pos_ok) begin
              cmd.res_load = 1'b1;
              cmd.res_status = pae_pkg::ST_BADPOS;
            end else begin
              cmd.mv_load = 1'b1;
              cmd.mv_mode = pae_pkg::MV_DEL;
            end
          end
          pae_pkg::OP_SEARCH: begin
            cmd.mv_load = 1'b1;
            cmd.mv_mode = pae_pkg::MV_SCAN;
          end
          pae_pkg::OP_READ: begin
            if (stat.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_status = pae_pkg::ST_EMPTY;
            end else if (!stat.pos_ok) begin
              cmd.res_load = 1'b1;
              cmd.res_status = pae_pkg::ST_BADPOS;
            end else begin
              cmd.mv_load = 1'b1;
              cmd.mv_mode = pae_pkg::MV_READ;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
          end
        endcase
      end
      pae_pkg::S_MOVE: begin
        cmd.mv_run = 1'b1;
        if (!stat.mv_busy && stat.op != pae_pkg::OP_INSERT) begin
          cmd.cnt_dec = 1'b1;
          cmd.res_load = 1'b1;
        end
      end
      pae_pkg::S_PUT: begin
        cmd.put_val = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.res_load = 1'b1;
      end
      pae_pkg::S_SCAN: begin
        cmd.mv_run = !stat.match;
        if (stat.match) begin
          cmd.res_load = 1'b1;
          cmd.res_found = 1'b1;
        end else if (!stat.mv_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_status = pae_pkg::ST_NOTFOUND;
        end
      end
      pae_pkg::S_READ: begin
        cmd.mv_run = 1'b1;
        if (!stat.mv_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_rd = 1'b1;
        end
      end
      pae_pkg::S_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/pae_dpath.sv
// Datapath: entry memory, entry count, entry mover and result registers.
`timescale 1ns / 1ps

module pae_dpath #(
  parameter int DEPTH = pae_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  pae_pkg::pae_cmd_t   cmd,
  output pae_pkg::pae_stat_t  stat,
  input  logic [2:0]          opcode,
  input  logic [7:0]          position,
  input  logic [31:0]         data_value,
  output logic [2:0]          status,
  output logic [31:0]         read_value,
  output logic [7:0]          found_position,
  output logic [7:0]          entry_count
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

  logic [31:0] mem [DEPTH];

  // captured command
  pae_pkg::op_t op_q;
  logic [7:0]   pos_q;
  logic [31:0]  val_q;

  logic [CW-1:0] count;

  // mover
  pae_pkg::mv_mode_t mode;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     raddr_q;
  logic [CW-1:0]     remain;
  logic              rvalid;
  logic [31:0]       rdata;
  logic              rd_en;

  logic [CMPW-1:0] pos_w, cnt_w;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [31:0]     wdata;
  logic [AW:0]     hit_pos;

  pae_pkg::st_t st_q;
  logic [31:0]  rd_val_q;
  logic [7:0]   found_q;

  assign pos_w = CMPW'(pos_q);
  assign cnt_w = CMPW'(count);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= pae_pkg::op_t'(opcode);
      pos_q <= position;
      val_q <= data_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clear) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  assign rd_en = cmd.mv_run && (remain != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      rvalid <= 1'b0;
    end else if (cmd.mv_load) begin
      rvalid <= 1'b0;
      case (cmd.mv_mode)
        pae_pkg::MV_INS:  remain <= CW'(cnt_w - pos_w + CMPW'(1));
        pae_pkg::MV_DEL:  remain <= CW'(cnt_w - pos_w);
        pae_pkg::MV_SCAN: remain <= count;
        pae_pkg::MV_READ: remain <= CW'(1);
        default:          remain <= '0;
      endcase
    end else begin
      rvalid <= rd_en;
      if (rd_en) remain <= remain - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mv_load) begin
      mode <= cmd.mv_mode;
      case (cmd.mv_mode)
        pae_pkg::MV_INS:  rd_addr <= AW'(cnt_w - CMPW'(1));
        pae_pkg::MV_DEL:  rd_addr <= AW'(pos_w);
        pae_pkg::MV_SCAN: rd_addr <= '0;
        pae_pkg::MV_READ: rd_addr <= AW'(pos_w - CMPW'(1));
        default:          rd_addr <= '0;
      endcase
    end else if (rd_en) begin
      // insert walks down from the top, everything else walks up
      if (mode == pae_pkg::MV_INS) rd_addr <= rd_addr - AW'(1);
      else rd_addr <= rd_addr + AW'(1);
    end
  end

  // memory write: either a moved entry or the inserted value
  assign we = cmd.put_val ||
              (rvalid && (mode == pae_pkg::MV_INS || mode == pae_pkg::MV_DEL));

  always_comb begin
    if (cmd.put_val) begin
      waddr = AW'(pos_w - CMPW'(1));
      wdata = val_q;
    end else if (mode == pae_pkg::MV_INS) begin
      waddr = raddr_q + AW'(1);
      wdata = rdata;
    end else begin
      waddr = raddr_q - AW'(1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata   <= mem[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  assign hit_pos = {1'b0, raddr_q} + (AW + 1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      st_q     <= cmd.res_status;
      rd_val_q <= cmd.res_rd ? rdata : 32'd0;
      found_q  <= cmd.res_found ? 8'(hit_pos) : 8'd0;
    end
  end

  always_comb begin
    stat.op         = op_q;
    stat.empty      = (count == '0);
    stat.full       = (count == CW'(DEPTH));
    stat.ins_pos_ok = (pos_q != 8'd0) && (pos_w <= cnt_w + CMPW'(1));
    stat.pos_ok     = (pos_q != 8'd0) && (pos_w <= cnt_w);
    stat.mv_busy    = (remain != '0) || rvalid;
    stat.match      = rvalid && (rdata == val_q);
  end

  assign status         = st_q;
  assign read_value     = rd_val_q;
  assign found_position = found_q;
  assign entry_count    = 8'(count);

endmodule

// File: rtl/core/positional_array_engine_unit.sv
// Top level of the positional array engine: controller plus datapath.
`timescale 1ns / 1ps
//
// Ordered store of up to DEPTH signed 32-bit entries with an entry count.
// Command channel: a beat (opcode, position, data_value) is taken at a clock
// edge where start is high and busy is low. busy stays high until the
// result has been shown, so one command is in flight at a time.
// Result channel: done is high for exactly one cycle; status, read_value,
// found_position and entry_count are valid in that cycle. The receiver has
// no back-pressure and must take the beat when done is high.
// Clear, rejected commands and unknown opcodes finish without moving any
// entries. Read fetches the one entry at the position; insert and delete
// shift the entries between the position and the count; search scans from
// the first entry until a match or the end of the stored entries. The
// memory has one read and one write port, so shifting or scanning moves
// one entry per cycle.
// Reset (rst, synchronous) empties the store and idles the controller;
// entry contents are not cleared, since nothing past the count is read.
//
module positional_array_engine_unit #(
  parameter int DEPTH = pae_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [7:0]         position,
  input  logic signed [31:0] data_value,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] read_value,
  output logic [7:0]         found_position,
  output logic [7:0]         entry_count
);

  pae_pkg::pae_cmd_t  cmd;
  pae_pkg::pae_stat_t stat;

  // sequencing only; no payload passes through here
  pae_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // storage, count, mover and result registers
  pae_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (opcode),
    .position       (position),
    .data_value     (data_value),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

endmodule

// File: rtl/core/pae_checker.sv
// Port-level checker for the positional array engine, bound to the top level.
`timescale 1ns / 1ps

module pae_checker #(
  parameter int DEPTH = pae_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [7:0]  found_position,
  input logic [7:0]  entry_count
);

  // a result only appears while a command is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // an accepted command blocks the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // a full reject only happens at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == 3'(pae_pkg::ST_FULL)) |-> entry_count == 8'(DEPTH))
    else $error("full status below capacity");

  // no position is reported for a miss
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    (done && status == 3'(pae_pkg::ST_NOTFOUND)) |-> found_position == 8'd0)
    else $error("position reported on a miss");

  // a hit position lies within the stored entries
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    (done && found_position != 8'd0) |->
      (status == 3'(pae_pkg::ST_OK) && found_position <= entry_count))
    else $error("hit position out of range");

endmodule

bind positional_array_engine_unit pae_checker #(
  .DEPTH (DEPTH)
) u_pae_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .found_position (found_position),
  .entry_count    (entry_count)
);

// File: tb/sv/testbench.sv
// Testbench for the positional array engine: directed and random commands, checked per beat.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = pae_pkg::DEPTH_DEFAULT;
  // Longest legal quiet stretch is one shift or scan plus a sender gap;
  // this is several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 120;

  // One expected result beat.
  typedef struct {
    pae_pkg::st_t status;
    logic [31:0]  read_value;
    logic [7:0]   found_position;
    logic [7:0]   entry_count;
  } pae_result_t;

  // Mirror of the store plus the queue of results still owed by the DUT.
  class pae_scoreboard;
    logic [31:0] entries [DEPTH];
    int          count;
    pae_result_t pending_results [$];
    int          failures;

    function new();
      count    = 0;
      failures = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    // Apply one accepted command to the mirror and queue its result.
    function void note_command(logic [2:0] op, logic [7:0] pos, logic [31:0] val);
      pae_result_t r;
      r.status         = pae_pkg::ST_OK;
      r.read_value     = '0;
      r.found_position = '0;
      case (op)
        pae_pkg::OP_CLEAR: begin
          count = 0;
        end
        pae_pkg::OP_INSERT: begin
          // full wins over a bad position
          if (count >= DEPTH) begin
            r.status = pae_pkg::ST_FULL;
          end else if (pos < 1 || pos > count + 1) begin
            r.status = pae_pkg::ST_BADPOS;
          end else begin
            for (int i = count; i >= pos; i--) entries[i] = entries[i-1];
            entries[pos-1] = val;
            count++;
          end
        end
        pae_pkg::OP_DELETE: begin
          if (count == 0) begin
            r.status = pae_pkg::ST_EMPTY;
          end else if (pos < 1 || pos > count) begin
            r.status = pae_pkg::ST_BADPOS;
          end else begin
            for (int i = pos - 1; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
          end
        end
        pae_pkg::OP_SEARCH: begin
          r.status = pae_pkg::ST_NOTFOUND;
          for (int i = 0; i < count; i++) begin
            if (entries[i] == val) begin
              r.found_position = 8'(i + 1);
              r.status         = pae_pkg::ST_OK;
              break;
            end
          end
        end
        pae_pkg::OP_READ: begin
          if (count == 0) begin
            r.status = pae_pkg::ST_EMPTY;
          end else if (pos < 1 || pos > count) begin
            r.status = pae_pkg::ST_BADPOS;
          end else begin
            r.read_value = entries[pos-1];
          end
        end
        default: ;  // unknown opcode: ok, nothing changes
      endcase
      r.entry_count = 8'(count);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        failures++;
      end
    endfunction

    // Check one result beat against the oldest expectation.
    function void check_result(logic [2:0] st, logic [31:0] rv, logic [7:0] fp,
                               logic [7:0] cnt);
      pae_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        failures++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("status", 32'(e.status), 32'(st));
      compare_field("read_value", e.read_value, rv);
      compare_field("found_position", 32'(e.found_position), 32'(fp));
      compare_field("entry_count", 32'(e.entry_count), 32'(cnt));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         opcode = '0;
  logic [7:0]         position = '0;
  logic signed [31:0] data_value = '0;
  logic               done;
  logic [2:0]         status;
  logic signed [31:0] read_value;
  logic [7:0]         found_position;
  logic [7:0]         entry_count;

  pae_scoreboard sb;
  int            sender_idle_pct = 0;
  int            quiet_cycles = 0;
  // sender idle percentage per phase; the receiver has no stall, so the
  // receiver-only phase runs flat out
  int            phase_idle [4] = '{0, 51, 0, 29};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_array_engine_unit #(.DEPTH(DEPTH)) u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .position       (position),
    .data_value     (data_value),
    .done           (done),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  // Monitor: sample at the rising edge. A result beat is checked before a new
  // command is noted, though the two cannot land on the same edge, since busy
  // is high while done is. Also runs the no-progress watchdog.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) sb.check_result(status, read_value, found_position, entry_count);
      if (start && !busy) sb.note_command(opcode, position, data_value);
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Drive one command beat at the falling edge and hold it until taken.
  // start stays high on return so back-to-back beats need no toggle.
  task automatic send_command(input logic [2:0] op, input logic [7:0] pos,
                              input logic [31:0] val);
    logic taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start      = 1'b1;
    opcode     = op;
    position   = pos;
    data_value = val;
    do begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  // Extremes often, a small pool to force duplicate entries, else anything.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal commands against the current count, some bad positions,
  // a few clears and unknown opcodes. Searches usually hit a stored value.
  task automatic random_command();
    int          cnt;
    int          sel;
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] val;
    cnt = sb.count;
    sel = $urandom_range(99);
    val = pick_value();
    if (sel < 2)       op = pae_pkg::OP_CLEAR;
    else if (sel < 5)  op = 3'($urandom_range(7, 5));
    else if (sel < 40) op = pae_pkg::OP_INSERT;
    else if (sel < 60) op = pae_pkg::OP_DELETE;
    else if (sel < 78) op = pae_pkg::OP_SEARCH;
    else               op = pae_pkg::OP_READ;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0:       pos = 8'd0;
        1:       pos = 8'(cnt + ((op == pae_pkg::OP_INSERT) ? 2 : 1));
        default: pos = 8'($urandom_range(255));
      endcase
    end else if (op == pae_pkg::OP_INSERT) begin
      pos = 8'($urandom_range(cnt + 1, 1));
    end else begin
      pos = (cnt > 0) ? 8'($urandom_range(cnt, 1)) : 8'($urandom_range(3));
    end
    if (op == pae_pkg::OP_SEARCH && cnt > 0 && $urandom_range(9) < 6)
      val = sb.entries[$urandom_range(cnt - 1)];
    send_command(op, pos, val);
  endtask

  // Build a full store from scratch, then poke at the full corner.
  task automatic fill_store();
    send_command(pae_pkg::OP_CLEAR, 8'd0, 32'd0);
    while (sb.count < DEPTH)
      send_command(pae_pkg::OP_INSERT, 8'($urandom_range(sb.count + 1, 1)), pick_value());
    send_command(pae_pkg::OP_INSERT, 8'(DEPTH + 1), pick_value());  // full beats bad position
    send_command(pae_pkg::OP_INSERT, 8'd1, 32'd0);
    send_command(pae_pkg::OP_READ, 8'(DEPTH), 32'd0);
    send_command(pae_pkg::OP_SEARCH, 8'd0, sb.entries[DEPTH-1]);
    send_command(pae_pkg::OP_DELETE, 8'(DEPTH), 32'd0);
    send_command(pae_pkg::OP_DELETE, 8'd1, 32'd0);
  endtask

  // Empty-store errors, position limits, ends and middle of the array,
  // duplicate search, unknown opcodes, clear.
  task automatic run_directed();
    send_command(pae_pkg::OP_READ,   8'd1,   32'd0);
    send_command(pae_pkg::OP_DELETE, 8'd1,   32'd0);
    send_command(pae_pkg::OP_SEARCH, 8'd0,   32'd0);
    send_command(pae_pkg::OP_INSERT, 8'd0,   32'd5);
    send_command(pae_pkg::OP_INSERT, 8'd2,   32'd5);
    send_command(pae_pkg::OP_INSERT, 8'd1,   32'h8000_0000);
    send_command(pae_pkg::OP_INSERT, 8'd2,   32'h7fff_ffff);
    send_command(pae_pkg::OP_INSERT, 8'd2,   32'h0000_0000);
    send_command(pae_pkg::OP_INSERT, 8'd1,   32'hffff_ffff);
    send_command(pae_pkg::OP_INSERT, 8'd4,   32'hffff_ffff);  // duplicate further down
    send_command(pae_pkg::OP_SEARCH, 8'd0,   32'hffff_ffff);
    send_command(pae_pkg::OP_SEARCH, 8'd255, 32'h7fff_ffff);
    send_command(pae_pkg::OP_SEARCH, 8'd0,   32'd12345);
    send_command(pae_pkg::OP_READ,   8'd5,   32'd0);
    send_command(pae_pkg::OP_READ,   8'd6,   32'd0);
    send_command(pae_pkg::OP_READ,   8'd255, 32'd0);
    send_command(pae_pkg::OP_READ,   8'd0,   32'd0);
    send_command(pae_pkg::OP_DELETE, 8'd0,   32'd0);
    send_command(pae_pkg::OP_DELETE, 8'd6,   32'd0);
    send_command(pae_pkg::OP_DELETE, 8'd5,   32'd0);
    send_command(pae_pkg::OP_DELETE, 8'd1,   32'd0);
    send_command(3'd5,               8'd255, 32'hffff_ffff);
    send_command(3'd6,               8'd128, 32'h8000_0000);
    send_command(3'd7,               8'd1,   32'd0);
    send_command(pae_pkg::OP_CLEAR,  8'd0,   32'd0);
  endtask

  initial begin
    sb = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = phase_idle[ph];
      if (ph == 1 || ph == 3) fill_store();
      repeat (RANDOM_PER_PHASE) random_command();
    end
    start = 1'b0;
    // drain, then linger long enough to catch a stray late beat
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DEPTH + 16) @(negedge clk);
    if (sb.failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
